// ===== sv/alt_pkg.sv =====
// Shared constants, codes and types for the address learning table.
package alt_pkg;

	// Table geometry
	localparam int unsigned ENTRIES = 32;
	localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned ADDR_W  = 2 * HALF_W;

	typedef logic [IDX_W-1:0] idx_t;

	// Request opcodes
	typedef enum logic {
		OP_LEARN  = 1'b0,
		OP_LOOKUP = 1'b1
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_MATCH     = 2'd0,
		ST_INSERTED  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Sequencer to scan unit
	typedef struct packed {
		logic clear;      // start of a new request: forget previous search
		logic cmp_vld;    // key read data for entry idx is on the bus
		idx_t idx;        // entry whose read data is being compared
		logic set_valid;  // mark entry set_idx as occupied
		idx_t set_idx;
	} scan_ctl_t;

	// Scan unit to sequencer
	typedef struct packed {
		logic match;
		idx_t match_idx;
		logic free;
		idx_t free_idx;
	} scan_res_t;

endpackage

// ===== sv/address_learning_table.sv =====
// Top level of the address learning table: sequencer, key and address memories.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | req_valid / req_stall | opcode, node_key, addr_high, addr_low
//  rsp     | out       | rsp_valid / rsp_stall | status, hit, found_high, found_low
//
// Each request steps through the sequencer states in order: accept in S_IDLE, key
// reads of every entry through the single key memory read port in S_SCAN, a compare
// of the last entry in S_DRAIN, write back or address read in S_ACT, response load in S_RESP.
// Reset clears the occupancy bits and all control state; the memories are not cleared.
// A stalled response holds in its register; the sequencer holds the finished result
// until the register frees, and the next request is stalled until then.
module address_learning_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       opcode,
	input  logic [alt_pkg::KEY_W-1:0]  node_key,
	input  logic [alt_pkg::HALF_W-1:0] addr_high,
	input  logic [alt_pkg::HALF_W-1:0] addr_low,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [1:0]                 status,
	output logic                       hit,
	output logic [alt_pkg::HALF_W-1:0] found_high,
	output logic [alt_pkg::HALF_W-1:0] found_low
);
	import alt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_ACT   = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	idx_t                scan_idx_q;
	idx_t                idx_s1;
	logic                cmp_vld_s1;
	opcode_t             op_q;
	logic [KEY_W-1:0]    key_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                rsp_valid_q;
	status_t             status_q;
	logic                hit_q;
	logic [HALF_W-1:0]   found_high_q;
	logic [HALF_W-1:0]   found_low_q;

	logic                accept;
	logic                scan_last;
	logic                rsp_load;
	scan_ctl_t           ctl;
	scan_res_t           res;
	logic [KEY_W-1:0]    key_rdata;
	logic [ADDR_W-1:0]   addr_rdata;
	logic                key_we;
	logic                addr_we;
	idx_t                addr_waddr;
	logic                addr_re;
	status_t             status_d;
	logic                hit_d;
	logic [ADDR_W-1:0]   found_d;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign scan_last = (scan_idx_q == idx_t'(ENTRIES - 1));
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_ACT;
			S_ACT:   state_d = S_RESP;
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			idx_s1     <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == S_SCAN);
			idx_s1     <= scan_idx_q;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (state_q == S_SCAN && !scan_last) begin
				scan_idx_q <= scan_idx_q + idx_t'(1);
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode_t'(opcode);
			key_q  <= node_key;
			addr_q <= {addr_high, addr_low};
		end
	end

	// Scan unit control
	always_comb begin
		ctl.clear     = accept;
		ctl.cmp_vld   = cmp_vld_s1;
		ctl.idx       = idx_s1;
		ctl.set_valid = (state_q == S_ACT) && (op_q == OP_LEARN) && !res.match && res.free;
		ctl.set_idx   = res.free_idx;
	end

	alt_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.key_rdata (key_rdata),
		.key_req   (key_q),
		.res       (res)
	);

	// Write back on learn, read the address on lookup hit
	assign key_we     = ctl.set_valid;
	assign addr_we    = (state_q == S_ACT) && (op_q == OP_LEARN) && (res.match || res.free);
	assign addr_waddr = res.match ? res.match_idx : res.free_idx;
	assign addr_re    = (state_q == S_ACT) && (op_q == OP_LOOKUP) && res.match;

	alt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (res.free_idx),
		.wdata (key_q),
		.re    (state_q == S_SCAN),
		.raddr (scan_idx_q),
		.rdata (key_rdata)
	);

	alt_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (ENTRIES)
	) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (addr_waddr),
		.wdata (addr_q),
		.re    (addr_re),
		.raddr (res.match_idx),
		.rdata (addr_rdata)
	);

	// Form the response
	always_comb begin
		hit_d   = res.match;
		found_d = '0;
		if (op_q == OP_LEARN) begin
			if (res.match) begin
				status_d = ST_MATCH;
			end else if (res.free) begin
				status_d = ST_INSERTED;
			end else begin
				status_d = ST_FULL;
			end
		end else begin
			if (res.match) begin
				status_d = ST_MATCH;
				found_d  = addr_rdata;
			end else begin
				status_d = ST_NOT_FOUND;
			end
		end
	end

	// Response register: drop valid once taken, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q     <= status_d;
			hit_q        <= hit_d;
			found_high_q <= found_d[ADDR_W-1:HALF_W];
			found_low_q  <= found_d[HALF_W-1:0];
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign hit        = hit_q;
	assign found_high = found_high_q;
	assign found_low  = found_low_q;

endmodule

// ===== sv/alt_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module alt_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port: hold the last read word when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/alt_scan.sv =====
// Occupancy bits and the per-entry match / free-slot tracker of the table scan.
module alt_scan (
	input  logic                     clk,
	input  logic                     arst_n,
	input  alt_pkg::scan_ctl_t       ctl,
	input  logic [alt_pkg::KEY_W-1:0] key_rdata,
	input  logic [alt_pkg::KEY_W-1:0] key_req,
	output alt_pkg::scan_res_t       res
);
	import alt_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic               match_q;
	idx_t               match_idx_q;
	logic               free_q;
	idx_t               free_idx_q;
	logic               ent_valid;
	logic               hit_now;
	logic               free_now;

	// Compare the entry whose key has just been read
	assign ent_valid = valid_q[ctl.idx];
	assign hit_now   = ctl.cmp_vld && ent_valid && (key_rdata == key_req);
	assign free_now  = ctl.cmp_vld && !ent_valid;

	// Occupancy: set on insert, never cleared but by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.set_valid) begin
			valid_q[ctl.set_idx] <= 1'b1;
		end
	end

	// Keep the first match and the lowest free slot seen so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			if (hit_now && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= ctl.idx;
			end
			if (free_now && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= ctl.idx;
			end
		end
	end

	assign res.match     = match_q;
	assign res.match_idx = match_idx_q;
	assign res.free      = free_q;
	assign res.free_idx  = free_idx_q;

endmodule
